FILE: hw/rtl/srvreg_pkg.sv
// Shared types and constants of the server registry.
// Used by srvreg_ctrl, srvreg_dp and server_registry_with_aging.
package srvreg_pkg;

  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int TIME_W   = 32;
  localparam int FIELD_W  = 16;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 7;
  localparam int MASK_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int MAX_SRV_W = 7;
  localparam int MAX_ROWS = 64;

  localparam logic [MAX_SRV_W-1:0] SRV_LIMIT_RST    = 7'd64;
  localparam logic [FIELD_W-1:0]   HB_TIMEOUT_RST   = 16'd2;
  localparam logic [FIELD_W-1:0]   INFO_TIMEOUT_RST = 16'd900;

  localparam logic [CFG_IDX_W-1:0] REG_SRV_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HB_TIMEOUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INFO_TIMEOUT = 2'd2;

  localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STS_ADDED     = 3'd1;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] STS_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] STS_BAD_CHAL  = 3'd4;
  localparam logic [STATUS_W-1:0] STS_INVALID   = 3'd5;

  typedef enum logic [1:0] {
    MODE_HEARTBEAT = 2'd0,
    MODE_INFO      = 2'd1,
    MODE_QUERY     = 2'd2,
    MODE_EXPIRE    = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FIND,
    S_MOD,
    S_ALLOC,
    S_WRITE,
    S_QUERY,
    S_QEND,
    S_EXPIRE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_go;
    logic scan_stop;
    logic mod_go;
    logic mod_step;
    logic alloc_go;
    logic clr_step;
    logic take_hit;
    logic take_free;
    logic commit;
    logic emit_full;
    logic emit_nf;
    logic q_push;
    logic q_end;
    logic exp_step;
    logic exp_end;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    mode_t req_mode;
    logic  clr_done;
    logic  eval_vld;
    logic  scan_done;
    logic  mod_done;
    logic  hit_find;
    logic  hit_free;
    logic  hit_query;
    logic  rows_last;
    logic  table_full;
  } stat_t;

endpackage

FILE: hw/rtl/srvreg_ctrl.sv
// Sequencer of the server registry: walks each operation through its scan phases.
// Depends on srvreg_pkg; drives srvreg_dp through cmd_t and reads stat_t.
module srvreg_ctrl import srvreg_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          unique case (mode_t'(stat.req_mode))
            MODE_HEARTBEAT, MODE_INFO: state_nxt = S_FIND;
            MODE_QUERY:                state_nxt = S_QUERY;
            MODE_EXPIRE:               state_nxt = S_EXPIRE;
            default:                   state_nxt = S_IDLE;
          endcase
        end
      end
      S_FIND: begin
        if (stat.eval_vld && stat.hit_find) begin
          state_nxt = S_WRITE;
        end else if (stat.scan_done) begin
          if (stat.mode == MODE_HEARTBEAT && !stat.table_full) state_nxt = S_MOD;
          else state_nxt = S_IDLE;
        end
      end
      S_MOD: begin
        if (stat.mod_done) state_nxt = S_ALLOC;
      end
      S_ALLOC: begin
        if (stat.eval_vld && stat.hit_free) state_nxt = S_WRITE;
      end
      S_WRITE: state_nxt = S_IDLE;
      S_QUERY: begin
        if ((stat.eval_vld && stat.hit_query && stat.rows_last) || stat.scan_done) begin
          state_nxt = S_QEND;
        end
      end
      S_QEND: state_nxt = S_IDLE;
      S_EXPIRE: begin
        if (stat.scan_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        busy = 1'b0;
        // load the item and start the full-table walk in the same cycle
        if (start) begin
          cmd.load    = 1'b1;
          cmd.scan_go = 1'b1;
        end
      end
      S_FIND: begin
        if (stat.eval_vld && stat.hit_find) begin
          cmd.take_hit  = 1'b1;
          cmd.scan_stop = 1'b1;
        end else if (stat.scan_done) begin
          if (stat.mode != MODE_HEARTBEAT) cmd.emit_nf = 1'b1;
          else if (stat.table_full) cmd.emit_full = 1'b1;
          else cmd.mod_go = 1'b1;
        end
      end
      S_MOD: begin
        if (stat.mod_done) cmd.alloc_go = 1'b1;
        else cmd.mod_step = 1'b1;
      end
      S_ALLOC: begin
        if (stat.eval_vld && stat.hit_free) begin
          cmd.take_free = 1'b1;
          cmd.scan_stop = 1'b1;
        end
      end
      S_WRITE: cmd.commit = 1'b1;
      S_QUERY: begin
        if (stat.eval_vld && stat.hit_query) begin
          cmd.q_push = 1'b1;
          if (stat.rows_last) cmd.scan_stop = 1'b1;
        end
      end
      S_QEND: cmd.q_end = 1'b1;
      S_EXPIRE: begin
        cmd.exp_step = 1'b1;
        if (stat.scan_done) cmd.exp_end = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

FILE: hw/rtl/srvreg_dp.sv
// Datapath of the server registry: entry memories, scan pointer, modulo unit,
// configuration registers and the result register. Depends on srvreg_pkg.
module srvreg_dp import srvreg_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [1:0]             in_mode,
  input  logic [TIME_W-1:0]      in_now,
  input  logic [ADDR_W-1:0]      in_address,
  input  logic [PORT_W-1:0]      in_port,
  input  logic                   in_game_kind,
  input  logic                   in_challenge_ok,
  input  logic [MASK_W-1:0]      in_present_mask,
  input  logic [FIELD_W-1:0]     in_protocol,
  input  logic [FIELD_W-1:0]     in_max_clients,
  input  logic [FIELD_W-1:0]     in_clients,
  input  logic                   in_want_empty,
  input  logic                   in_want_full,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DAT_W-1:0]   cfg_data,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  output logic                   out_strobe,
  output logic [STATUS_W-1:0]    out_status,
  output logic [SLOT_W-1:0]      out_slot,
  output logic [ADDR_W-1:0]      out_server_address,
  output logic [PORT_W-1:0]      out_server_port,
  output logic                   out_last,
  output logic [COUNT_W-1:0]     out_count
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int MCW   = $clog2(CNT_W + 1);
  localparam int ROW_W = $clog2(MAX_ROWS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  // configuration
  logic [MAX_SRV_W-1:0] cfg_max_r;
  logic [FIELD_W-1:0]   cfg_hb_r, cfg_info_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_max_r  <= SRV_LIMIT_RST;
      cfg_hb_r   <= HB_TIMEOUT_RST;
      cfg_info_r <= INFO_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRV_LIMIT:    cfg_max_r  <= MAX_SRV_W'(cfg_data);
        REG_HB_TIMEOUT:   cfg_hb_r   <= cfg_data;
        REG_INFO_TIMEOUT: cfg_info_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] cap_w;
  always_comb begin
    if (cfg_max_r == '0) cap_w = CNT_W'(1);
    else if (int'(cfg_max_r) > TABLE_DEPTH) cap_w = CNT_W'(TABLE_DEPTH);
    else cap_w = CNT_W'(cfg_max_r);
  end

  // item registers
  mode_t              mode_r;
  logic [TIME_W-1:0]  now_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [PORT_W-1:0]  port_r;
  logic               game_r, chal_r, want_empty_r, want_full_r;
  logic [MASK_W-1:0]  mask_r;
  logic [FIELD_W-1:0] proto_r, maxc_r, cli_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r       <= mode_t'(in_mode);
      now_r        <= in_now;
      addr_r       <= in_address;
      port_r       <= in_port;
      game_r       <= in_game_kind;
      chal_r       <= in_challenge_ok;
      mask_r       <= in_present_mask;
      proto_r      <= in_protocol;
      maxc_r       <= in_max_clients;
      cli_r        <= in_clients;
      want_empty_r <= in_want_empty;
      want_full_r  <= in_want_full;
    end
  end

  // entry memories
  logic               mem_valid    [TABLE_DEPTH];
  logic [ADDR_W-1:0]  mem_addr     [TABLE_DEPTH];
  logic [PORT_W-1:0]  mem_port     [TABLE_DEPTH];
  logic               mem_game     [TABLE_DEPTH];
  logic [FIELD_W-1:0] mem_proto    [TABLE_DEPTH];
  logic [FIELD_W-1:0] mem_capacity [TABLE_DEPTH];
  logic [FIELD_W-1:0] mem_players  [TABLE_DEPTH];
  logic [TIME_W-1:0]  mem_deadline [TABLE_DEPTH];

  logic               q_valid, q_game;
  logic [ADDR_W-1:0]  q_addr;
  logic [PORT_W-1:0]  q_port;
  logic [FIELD_W-1:0] q_proto, q_capacity, q_players;
  logic [TIME_W-1:0]  q_deadline;

  // scan pointer
  logic [IDX_W-1:0] rd_idx_r, wrap_r, eval_idx_r;
  logic [CNT_W-1:0] left_r;
  logic             eval_vld_r;
  logic             issue;
  logic [IDX_W-1:0] ap_r;
  logic [CNT_W-1:0] cnt_r, div_r, rem_r;

  assign issue = (left_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r     <= '0;
      eval_vld_r <= 1'b0;
    end else if (cmd.scan_stop) begin
      left_r     <= '0;
      eval_vld_r <= 1'b0;
    end else if (cmd.scan_go) begin
      left_r     <= CNT_W'(TABLE_DEPTH);
      eval_vld_r <= 1'b0;
    end else if (cmd.alloc_go) begin
      left_r     <= cap_w;
      eval_vld_r <= 1'b0;
    end else begin
      if (issue) left_r <= left_r - 1'b1;
      eval_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_go) begin
      rd_idx_r <= '0;
      wrap_r   <= LAST_IDX;
    end else if (cmd.alloc_go) begin
      rd_idx_r <= IDX_W'(rem_r);
      wrap_r   <= IDX_W'(cap_w - 1'b1);
    end else if (issue) begin
      rd_idx_r <= (rd_idx_r == wrap_r) ? '0 : rd_idx_r + 1'b1;
    end
    if (issue) eval_idx_r <= rd_idx_r;
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      q_valid    <= mem_valid[rd_idx_r];
      q_addr     <= mem_addr[rd_idx_r];
      q_port     <= mem_port[rd_idx_r];
      q_game     <= mem_game[rd_idx_r];
      q_proto    <= mem_proto[rd_idx_r];
      q_capacity <= mem_capacity[rd_idx_r];
      q_players  <= mem_players[rd_idx_r];
      q_deadline <= mem_deadline[rd_idx_r];
    end
  end

  logic hit_find, hit_free, hit_query, hit_expire, stale;
  assign stale      = (q_deadline < now_r);
  assign hit_find   = q_valid && (q_addr == addr_r) && (q_port == port_r);
  assign hit_free   = !q_valid;
  assign hit_expire = q_valid && stale;
  assign hit_query  = q_valid && (q_game == game_r) && (q_proto == proto_r)
                   && ((q_players != '0) || want_empty_r)
                   && ((q_players != q_capacity) || want_full_r) && !stale;

  // remainder of (alloc_pointer + 1) by the limit, one dividend bit a cycle
  logic [MCW-1:0]   mod_cnt_r;
  logic [CNT_W:0]   mod_t;

  always_comb begin
    mod_t = {rem_r, div_r[CNT_W-1]};
    if (mod_t >= {1'b0, cap_w}) mod_t = mod_t - {1'b0, cap_w};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_cnt_r <= '0;
    end else if (cmd.mod_go) begin
      mod_cnt_r <= MCW'(CNT_W);
    end else if (cmd.mod_step) begin
      mod_cnt_r <= mod_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_go) begin
      div_r <= CNT_W'(ap_r) + 1'b1;
      rem_r <= '0;
    end else if (cmd.mod_step) begin
      div_r <= div_r << 1;
      rem_r <= CNT_W'(mod_t);
    end
  end

  // clearing pass of the valid store after reset
  logic [IDX_W-1:0] clr_idx_r;
  always_ff @(posedge clk) begin
    if (!rst_n) clr_idx_r <= '0;
    else if (cmd.clr_step) clr_idx_r <= clr_idx_r + 1'b1;
  end

  // captured slot, query rows, removal count
  logic [IDX_W-1:0]   hit_idx_r, pend_idx_r;
  logic [FIELD_W-1:0] st_proto_r, st_cap_r;
  logic [ADDR_W-1:0]  pend_addr_r;
  logic [PORT_W-1:0]  pend_port_r;
  logic               found_r, pend_vld_r;
  logic [ROW_W-1:0]   rows_r;
  logic [CNT_W-1:0]   removed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r    <= 1'b0;
      pend_vld_r <= 1'b0;
      rows_r     <= '0;
      removed_r  <= '0;
    end else if (cmd.load) begin
      found_r    <= 1'b0;
      pend_vld_r <= 1'b0;
      rows_r     <= '0;
      removed_r  <= '0;
    end else begin
      if (cmd.take_hit) found_r <= 1'b1;
      if (cmd.q_push) begin
        pend_vld_r <= 1'b1;
        rows_r     <= rows_r + 1'b1;
      end
      if (cmd.exp_step && eval_vld_r && hit_expire) removed_r <= removed_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_hit || cmd.take_free) begin
      hit_idx_r  <= eval_idx_r;
      st_proto_r <= q_proto;
      st_cap_r   <= q_capacity;
    end
    if (cmd.q_push) begin
      pend_idx_r  <= eval_idx_r;
      pend_addr_r <= q_addr;
      pend_port_r <= q_port;
    end
  end

  // commit values
  logic [TIME_W:0]    dl_sum;
  logic [TIME_W-1:0]  deadline;
  logic [FIELD_W-1:0] new_proto, new_cap;
  logic               info_bad, is_hb;

  assign is_hb     = (mode_r == MODE_HEARTBEAT);
  assign dl_sum    = {1'b0, now_r} + (TIME_W+1)'(is_hb ? cfg_hb_r : cfg_info_r);
  assign deadline  = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];
  assign new_proto = mask_r[0] ? proto_r : st_proto_r;
  assign new_cap   = mask_r[1] ? maxc_r : st_cap_r;
  assign info_bad  = (new_proto == '0) || (new_cap == '0);

  // single write port
  logic [IDX_W-1:0]   wr_idx;
  logic               we_valid, we_key, we_game, we_proto, we_cap, we_pl, we_dl;
  logic               valid_d;
  logic [FIELD_W-1:0] proto_d, cap_d, pl_d;

  always_comb begin
    wr_idx   = hit_idx_r;
    we_valid = 1'b0;
    we_key   = 1'b0;
    we_game  = 1'b0;
    we_proto = 1'b0;
    we_cap   = 1'b0;
    we_pl    = 1'b0;
    we_dl    = 1'b0;
    valid_d  = 1'b0;
    proto_d  = '0;
    cap_d    = '0;
    pl_d     = '0;
    if (cmd.clr_step) begin
      wr_idx   = clr_idx_r;
      we_valid = 1'b1;
    end else if (cmd.exp_step && eval_vld_r && hit_expire) begin
      wr_idx   = eval_idx_r;
      we_valid = 1'b1;
    end else if (cmd.commit) begin
      if (is_hb) begin
        we_valid = !found_r;
        valid_d  = 1'b1;
        we_key   = 1'b1;
        we_game  = 1'b1;
        we_dl    = 1'b1;
        we_proto = !found_r;
        we_cap   = !found_r;
        we_pl    = !found_r;
      end else if (chal_r) begin
        we_proto = mask_r[0];
        we_cap   = mask_r[1];
        we_pl    = mask_r[2];
        proto_d  = proto_r;
        cap_d    = maxc_r;
        pl_d     = cli_r;
        we_dl    = !info_bad;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we_valid) mem_valid[wr_idx] <= valid_d;
    if (we_key) begin
      mem_addr[wr_idx] <= addr_r;
      mem_port[wr_idx] <= port_r;
    end
    if (we_game)  mem_game[wr_idx]     <= game_r;
    if (we_proto) mem_proto[wr_idx]    <= proto_d;
    if (we_cap)   mem_capacity[wr_idx] <= cap_d;
    if (we_pl)    mem_players[wr_idx]  <= pl_d;
    if (we_dl)    mem_deadline[wr_idx] <= deadline;
  end

  // table bookkeeping
  logic [CNT_W-1:0] cnt_nxt;
  logic [IDX_W-1:0] ap_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    ap_nxt  = ap_r;
    if (cmd.commit && is_hb && !found_r) begin
      cnt_nxt = cnt_r + 1'b1;
      ap_nxt  = hit_idx_r;
    end else if (cmd.exp_end) begin
      cnt_nxt = cnt_r - removed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ap_r  <= LAST_IDX;
    end else begin
      cnt_r <= cnt_nxt;
      ap_r  <= ap_nxt;
    end
  end

  // result register
  logic                out_strobe_r, out_strobe_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [PORT_W-1:0]   out_port_r, out_port_nxt;
  logic                out_last_r, out_last_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;

  always_comb begin
    out_strobe_nxt = 1'b1;
    out_status_nxt = STS_OK;
    out_slot_nxt   = '0;
    out_addr_nxt   = '0;
    out_port_nxt   = '0;
    out_last_nxt   = 1'b1;
    out_count_nxt  = COUNT_W'(cnt_nxt);
    if (cmd.q_push || cmd.q_end) begin
      // a row goes out once the next match or the end of the walk is known
      out_strobe_nxt = pend_vld_r || cmd.q_end;
      out_last_nxt   = cmd.q_end;
      if (pend_vld_r) begin
        out_slot_nxt = SLOT_W'(pend_idx_r);
        out_addr_nxt = pend_addr_r;
        out_port_nxt = pend_port_r;
      end else begin
        out_status_nxt = STS_NOT_FOUND;
      end
    end else if (cmd.emit_full) begin
      out_status_nxt = STS_FULL;
    end else if (cmd.emit_nf) begin
      out_status_nxt = STS_NOT_FOUND;
    end else if (cmd.commit) begin
      out_slot_nxt = SLOT_W'(hit_idx_r);
      if (is_hb) out_status_nxt = found_r ? STS_OK : STS_ADDED;
      else if (!chal_r) out_status_nxt = STS_BAD_CHAL;
      else if (info_bad) out_status_nxt = STS_INVALID;
      else out_status_nxt = STS_OK;
    end else if (cmd.exp_end) begin
      out_count_nxt = COUNT_W'(removed_r);
    end else begin
      out_strobe_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_strobe_nxt) begin
      out_status_r <= out_status_nxt;
      out_slot_r   <= out_slot_nxt;
      out_addr_r   <= out_addr_nxt;
      out_port_r   <= out_port_nxt;
      out_last_r   <= out_last_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_status         = out_status_r;
  assign out_slot           = out_slot_r;
  assign out_server_address = out_addr_r;
  assign out_server_port    = out_port_r;
  assign out_last           = out_last_r;
  assign out_count          = out_count_r;

  assign stat.mode       = mode_r;
  assign stat.req_mode   = mode_t'(in_mode);
  assign stat.clr_done   = (clr_idx_r == LAST_IDX);
  assign stat.eval_vld   = eval_vld_r;
  assign stat.scan_done  = !issue && !eval_vld_r;
  assign stat.mod_done   = (mod_cnt_r == '0);
  assign stat.hit_find   = hit_find;
  assign stat.hit_free   = hit_free;
  assign stat.hit_query  = hit_query;
  assign stat.rows_last  = (rows_r == ROW_W'(MAX_ROWS - 1));
  assign stat.table_full = (cnt_r >= cap_w);

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= TABLE_DEPTH)
    else $error("server count above table depth");

  a_alloc_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_go |-> (rem_r < cap_w))
    else $error("free-slot walk starts outside the limit");

  a_add_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && is_hb && !found_r) |-> (cnt_r < cap_w))
    else $error("server added to a full table");

  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_last_r && $past(cmd.commit)) |=> !out_strobe_r)
    else $error("extra result after a single-beat item");
`endif

endmodule

FILE: hw/rtl/server_registry_with_aging.sv
// Top level of the server registry with aging.
// Depends on srvreg_pkg, srvreg_ctrl and srvreg_dp.

// The registry takes one item at a time: start is accepted while busy is low,
// and results leave as one-cycle out_strobe beats that cannot be held off,
// the final beat of an item marked by out_last. Every operation walks the
// table one slot per cycle through the single read port of the entry
// memories. A known heartbeat or info update ends its walk early at the
// matching slot, and a new heartbeat adds the modulo steps and then a
// free-slot walk over up to the server limit. The last beat comes out in
// the same cycle that busy drops. After reset the valid store is cleared
// with busy high; configuration writes are always accepted through
// cfg_valid and belong between items.
module server_registry_with_aging import srvreg_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_mode,
  input  logic [TIME_W-1:0]    in_now,
  input  logic [ADDR_W-1:0]    in_address,
  input  logic [PORT_W-1:0]    in_port,
  input  logic                 in_game_kind,
  input  logic                 in_challenge_ok,
  input  logic [MASK_W-1:0]    in_present_mask,
  input  logic [FIELD_W-1:0]   in_protocol,
  input  logic [FIELD_W-1:0]   in_max_clients,
  input  logic [FIELD_W-1:0]   in_clients,
  input  logic                 in_want_empty,
  input  logic                 in_want_full,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output logic                 out_strobe,
  output logic [STATUS_W-1:0]  out_status,
  output logic [SLOT_W-1:0]    out_slot,
  output logic [ADDR_W-1:0]    out_server_address,
  output logic [PORT_W-1:0]    out_server_port,
  output logic                 out_last,
  output logic [COUNT_W-1:0]   out_count
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  srvreg_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  srvreg_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_mode            (in_mode),
    .in_now             (in_now),
    .in_address         (in_address),
    .in_port            (in_port),
    .in_game_kind       (in_game_kind),
    .in_challenge_ok    (in_challenge_ok),
    .in_present_mask    (in_present_mask),
    .in_protocol        (in_protocol),
    .in_max_clients     (in_max_clients),
    .in_clients         (in_clients),
    .in_want_empty      (in_want_empty),
    .in_want_full       (in_want_full),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .cmd                (cmd),
    .stat               (stat),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_slot           (out_slot),
    .out_server_address (out_server_address),
    .out_server_port    (out_server_port),
    .out_last           (out_last),
    .out_count          (out_count)
  );

endmodule

FILE: bench/server_registry_with_aging_test.sv
// Self-checking bench for server_registry_with_aging: directed table, then random phases.
// Predicts every result beat in-bench; depends only on srvreg_pkg and the block.
`timescale 1ns / 1ps

module server_registry_with_aging_test;
  import srvreg_pkg::*;

  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE = DEPTH + 20;
  localparam int POOL = 16;

  typedef struct {
    mode_t                mode;
    logic [TIME_W-1:0]    now;
    logic [ADDR_W-1:0]    address;
    logic [PORT_W-1:0]    port;
    logic                 game;
    logic                 chal;
    logic [MASK_W-1:0]    mask;
    logic [FIELD_W-1:0]   proto;
    logic [FIELD_W-1:0]   maxc;
    logic [FIELD_W-1:0]   cli;
    logic                 want_empty;
    logic                 want_full;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   address;
    logic [PORT_W-1:0]   port;
    logic                last;
    logic [COUNT_W-1:0]  count;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_mode;
  logic [TIME_W-1:0] in_now;
  logic [ADDR_W-1:0] in_address;
  logic [PORT_W-1:0] in_port;
  logic in_game_kind, in_challenge_ok;
  logic [MASK_W-1:0] in_present_mask;
  logic [FIELD_W-1:0] in_protocol, in_max_clients, in_clients;
  logic in_want_empty, in_want_full;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic out_strobe;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0] out_slot;
  logic [ADDR_W-1:0] out_server_address;
  logic [PORT_W-1:0] out_server_port;
  logic out_last;
  logic [COUNT_W-1:0] out_count;

  server_registry_with_aging #(.TABLE_DEPTH(DEPTH)) dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // registry mirror
  logic [MAX_SRV_W-1:0] srv_limit_q;
  logic [FIELD_W-1:0]   hb_timeout_q, info_timeout_q;
  logic                 live_q [DEPTH];
  logic [ADDR_W-1:0]    addr_q [DEPTH];
  logic [PORT_W-1:0]    port_q [DEPTH];
  logic                 game_q [DEPTH];
  logic [FIELD_W-1:0]   proto_q [DEPTH];
  logic [FIELD_W-1:0]   cap_q [DEPTH];
  logic [FIELD_W-1:0]   players_q [DEPTH];
  logic [TIME_W-1:0]    deadline_q [DEPTH];
  int unsigned          rr_ptr;
  int unsigned          held;

  reply_t pending_replies [$];
  int     mismatches = 0;
  int     cycles = 0;
  logic   [TIME_W-1:0] clock_now;
  logic   [ADDR_W-1:0] pool_addr [POOL];
  logic   [PORT_W-1:0] pool_port [POOL];

  function automatic logic [TIME_W-1:0] deadline_of(logic [TIME_W-1:0] t,
                                                     logic [FIELD_W-1:0] to);
    logic [TIME_W:0] s;
    s = {1'b0, t} + (TIME_W+1)'(to);
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  function automatic reply_t mk_reply(logic [STATUS_W-1:0] st, int sl, int cnt);
    reply_t r;
    r.status = st; r.slot = SLOT_W'(sl); r.address = '0; r.port = '0;
    r.last = 1'b1; r.count = COUNT_W'(cnt);
    return r;
  endfunction

  function automatic void registry_apply(request_t q);
    int s, rows;
    int unsigned cap, j;
    int unsigned removed;
    logic [STATUS_W-1:0] st;
    reply_t r;
    s = -1;
    for (int i = 0; i < DEPTH; i++)
      if (s < 0 && live_q[i] && addr_q[i] == q.address && port_q[i] == q.port) s = i;
    case (q.mode)
      MODE_HEARTBEAT: begin
        st = STS_OK;
        if (s < 0) begin
          cap = (srv_limit_q < 1) ? 1 : (srv_limit_q > DEPTH) ? DEPTH : srv_limit_q;
          if (held >= cap) begin
            pending_replies.push_back(mk_reply(STS_FULL, 0, held));
            return;
          end
          j = (rr_ptr + 1) % cap;
          for (int n = 0; n < cap; n++) begin
            if (!live_q[j]) break;
            j = (j + 1) % cap;
          end
          s = j;
          rr_ptr = j;
          live_q[s] = 1'b1;
          addr_q[s] = q.address; port_q[s] = q.port;
          proto_q[s] = '0; cap_q[s] = '0; players_q[s] = '0;
          held++;
          st = STS_ADDED;
        end
        game_q[s] = q.game;
        deadline_q[s] = deadline_of(q.now, hb_timeout_q);
        pending_replies.push_back(mk_reply(st, s, held));
      end
      MODE_INFO: begin
        if (s < 0) pending_replies.push_back(mk_reply(STS_NOT_FOUND, 0, held));
        else if (!q.chal) pending_replies.push_back(mk_reply(STS_BAD_CHAL, s, held));
        else begin
          if (q.mask[0]) proto_q[s] = q.proto;
          if (q.mask[1]) cap_q[s] = q.maxc;
          if (q.mask[2]) players_q[s] = q.cli;
          if (proto_q[s] == 0 || cap_q[s] == 0)
            pending_replies.push_back(mk_reply(STS_INVALID, s, held));
          else begin
            deadline_q[s] = deadline_of(q.now, info_timeout_q);
            pending_replies.push_back(mk_reply(STS_OK, s, held));
          end
        end
      end
      MODE_QUERY: begin
        rows = 0;
        for (int i = 0; i < DEPTH && rows < MAX_ROWS; i++) begin
          if (!live_q[i] || game_q[i] != q.game || proto_q[i] != q.proto) continue;
          if (players_q[i] == 0 && !q.want_empty) continue;
          if (players_q[i] == cap_q[i] && !q.want_full) continue;
          if (deadline_q[i] < q.now) continue;
          r = mk_reply(STS_OK, i, held);
          r.address = addr_q[i]; r.port = port_q[i]; r.last = 1'b0;
          pending_replies.push_back(r);
          rows++;
        end
        if (rows == 0) pending_replies.push_back(mk_reply(STS_NOT_FOUND, 0, held));
        else pending_replies[$].last = 1'b1;
      end
      default: begin
        removed = 0;
        for (int i = 0; i < DEPTH; i++)
          if (live_q[i] && deadline_q[i] < q.now) begin
            live_q[i] = 1'b0;
            removed++;
          end
        held -= removed;
        pending_replies.push_back(mk_reply(STS_OK, 0, removed));
      end
    endcase
  endfunction

  // result beats
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles,
               pending_replies.size());
      $display("** server_registry_with_aging: FAILED **");
      $finish;
    end
    if (rst_n && out_strobe) begin
      if (pending_replies.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected beat: status %0d slot %0d", out_status,
                                      out_slot);
      end else begin
        reply_t e;
        e = pending_replies.pop_front();
        if (out_status !== e.status || out_slot !== e.slot ||
            out_server_address !== e.address || out_server_port !== e.port ||
            out_last !== e.last || out_count !== e.count) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display({"mismatch @%0t exp st%0d sl%0d a%h p%h l%0d c%0d",
                      " got st%0d sl%0d a%h p%h l%0d c%0d"},
                     $realtime, e.status, e.slot, e.address, e.port, e.last, e.count,
                     out_status, out_slot, out_server_address, out_server_port, out_last,
                     out_count);
        end
      end
    end
  end

  task automatic send(request_t q, bit typed, reply_t ty);
    int depth0;
    @(negedge clk);
    in_mode = q.mode; in_now = q.now; in_address = q.address; in_port = q.port;
    in_game_kind = q.game; in_challenge_ok = q.chal; in_present_mask = q.mask;
    in_protocol = q.proto; in_max_clients = q.maxc; in_clients = q.cli;
    in_want_empty = q.want_empty; in_want_full = q.want_full;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    depth0 = pending_replies.size();
    registry_apply(q);
    if (typed) begin
      while (pending_replies.size() > depth0) void'(pending_replies.pop_back());
      pending_replies.push_back(ty);
    end
  endtask

  task automatic pause(int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    start = 1'b0;
    cfg_valid = 1'b1; cfg_index = idx; cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SRV_LIMIT:  srv_limit_q = val[MAX_SRV_W-1:0];
      REG_HB_TIMEOUT: hb_timeout_q = val;
      default:        info_timeout_q = val;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic request_t mk(mode_t m, logic [TIME_W-1:0] t, logic [ADDR_W-1:0] a,
                                  logic [PORT_W-1:0] p, logic g, logic ch,
                                  logic [MASK_W-1:0] mk_, logic [FIELD_W-1:0] pr,
                                  logic [FIELD_W-1:0] mc, logic [FIELD_W-1:0] cl,
                                  logic we, logic wf);
    request_t q;
    q.mode = m; q.now = t; q.address = a; q.port = p; q.game = g; q.chal = ch;
    q.mask = mk_; q.proto = pr; q.maxc = mc; q.cli = cl;
    q.want_empty = we; q.want_full = wf;
    return q;
  endfunction

  function automatic logic [FIELD_W-1:0] pick_small();
    logic [FIELD_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1, 2: v = FIELD_W'(1);
      3: v = FIELD_W'(2);
      4: v = FIELD_W'(8);
      5: v = 16'hFFFF;
      6: v = FIELD_W'($urandom);
      default: v = FIELD_W'($urandom_range(0, 3));
    endcase
    return v;
  endfunction

  function automatic request_t random_request();
    request_t q;
    int k, roll;
    roll = $urandom_range(0, 99);
    q.mode = roll < 35 ? MODE_HEARTBEAT : roll < 65 ? MODE_INFO :
             roll < 85 ? MODE_QUERY : MODE_EXPIRE;
    if ($urandom_range(0, 19) == 0) clock_now = $urandom;
    else clock_now = clock_now + $urandom_range(0, 3);
    q.now = clock_now;
    if ($urandom_range(0, 9) == 0) begin
      q.address = $urandom; q.port = PORT_W'($urandom);
    end else begin
      k = $urandom_range(0, POOL - 1);
      q.address = pool_addr[k]; q.port = pool_port[k];
    end
    q.game = 1'($urandom_range(0, 1));
    q.chal = $urandom_range(0, 7) != 0;
    q.mask = MASK_W'($urandom_range(0, 7));
    q.proto = ($urandom_range(0, 3) == 0) ? pick_small() :
              ($urandom_range(0, 1) ? FIELD_W'(1) : FIELD_W'(7));
    q.maxc = pick_small();
    q.cli = pick_small();
    q.want_empty = 1'($urandom_range(0, 1));
    q.want_full = 1'($urandom_range(0, 1));
    return q;
  endfunction

  request_t dir_req [16];
  bit       dir_typed [16];
  reply_t   dir_reply [16];

  initial begin
    reply_t none;
    int phase_cfg [6][3];
    int n_items;
    none = mk_reply(STS_OK, 0, 0);
    rst_n = 1'b0; start = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_mode = '0; in_now = '0; in_address = '0; in_port = '0; in_game_kind = 1'b0;
    in_challenge_ok = 1'b0; in_present_mask = '0; in_protocol = '0;
    in_max_clients = '0; in_clients = '0; in_want_empty = 1'b0; in_want_full = 1'b0;
    srv_limit_q = SRV_LIMIT_RST; hb_timeout_q = HB_TIMEOUT_RST;
    info_timeout_q = INFO_TIMEOUT_RST;
    for (int i = 0; i < DEPTH; i++) live_q[i] = 1'b0;
    rr_ptr = DEPTH - 1; held = 0; clock_now = 32'd1000;
    for (int i = 0; i < POOL; i++) begin
      pool_addr[i] = $urandom; pool_port[i] = PORT_W'($urandom_range(1, 65535));
    end
    pool_port[0] = '0;

    // after reset, extremes of key and time, the not-found, bad-challenge and invalid codes, port zero
    dir_req[0]  = mk(MODE_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1);
    dir_req[1]  = mk(MODE_INFO, 5, 32'h1234, 9, 0, 1, 7, 1, 1, 1, 0, 0);
    dir_req[2]  = mk(MODE_EXPIRE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_req[3]  = mk(MODE_HEARTBEAT, 100, '1, '1, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_req[4]  = mk(MODE_HEARTBEAT, 100, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0);
    dir_req[5]  = mk(MODE_HEARTBEAT, 100, '1, '1, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_req[6]  = mk(MODE_INFO, 100, 0, 0, 0, 0, 7, 5, 5, 5, 0, 0);
    dir_req[7]  = mk(MODE_INFO, 100, 0, 0, 0, 1, 0, 5, 5, 5, 0, 0);
    dir_req[8]  = mk(MODE_INFO, 32'hFFFF_FFF0, 0, 0, 0, 1, 7, '1, '1, '1, 0, 0);
    dir_req[9]  = mk(MODE_INFO, 100, '1, '1, 0, 1, 3, 1, 1, 0, 0, 0);
    dir_req[10] = mk(MODE_QUERY, 200, 0, 0, 1, 0, 0, '1, 0, 0, 0, 1);
    dir_req[11] = mk(MODE_QUERY, 200, 0, 0, 1, 0, 0, '1, 0, 0, 1, 0);
    dir_req[12] = mk(MODE_QUERY, 100, 0, 0, 0, 0, 0, 1, 0, 0, 1, 1);
    dir_req[13] = mk(MODE_INFO, 300, 0, 0, 1, 1, 4, 0, 0, 0, 0, 0);
    dir_req[14] = mk(MODE_EXPIRE, '1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_req[15] = mk(MODE_HEARTBEAT, '1, 32'h8000_0001, 16'h8000, 1, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 16; i++) dir_typed[i] = 1'b0;
    dir_reply[0] = mk_reply(STS_NOT_FOUND, 0, 0);  dir_typed[0] = 1;
    dir_reply[1] = mk_reply(STS_NOT_FOUND, 0, 0);  dir_typed[1] = 1;
    dir_reply[2] = mk_reply(STS_OK, 0, 0);         dir_typed[2] = 1;
    dir_reply[3] = mk_reply(STS_ADDED, 0, 1);      dir_typed[3] = 1;
    dir_reply[4] = mk_reply(STS_ADDED, 1, 2);      dir_typed[4] = 1;
    dir_reply[5] = mk_reply(STS_OK, 0, 2);         dir_typed[5] = 1;
    dir_reply[6] = mk_reply(STS_BAD_CHAL, 1, 2);   dir_typed[6] = 1;
    dir_reply[7] = mk_reply(STS_INVALID, 1, 2);    dir_typed[7] = 1;
    dir_reply[8] = mk_reply(STS_OK, 1, 2);         dir_typed[8] = 1;
    dir_reply[9] = mk_reply(STS_OK, 0, 2);         dir_typed[9] = 1;
    dir_reply[14] = mk_reply(STS_OK, 0, 2);        dir_typed[14] = 1;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < 16; i++) begin
      if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 6));
      send(dir_req[i], dir_typed[i], dir_typed[i] ? dir_reply[i] : none);
    end
    drain();

    // server limit, heartbeat timeout, info timeout per phase
    phase_cfg = '{'{1, 0, 0}, '{64, 65535, 65535}, '{3, 5, 100}, '{64, 10, 300},
                  '{2, 20, 40}, '{64, 2, 900}};
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_SRV_LIMIT, CFG_DAT_W'(phase_cfg[p][0]));
      write_reg(REG_HB_TIMEOUT, CFG_DAT_W'(phase_cfg[p][1]));
      write_reg(REG_INFO_TIMEOUT, CFG_DAT_W'(phase_cfg[p][2]));
      if (p == 1) clock_now = 32'hFFFF_FF00;
      n_items = (p == 1 || p == 3) ? 70 : 45;
      for (int i = 0; i < n_items; i++) begin
        if (p < 5 && $urandom_range(0, 3) == 0) pause($urandom_range(1, 6));
        if (i == n_items / 2 && p == 2) drain();
        send(random_request(), 1'b0, none);
      end
      drain();
    end

    if (mismatches == 0 && pending_replies.size() == 0)
      $display("** server_registry_with_aging: PASSED **");
    else
      $display("** server_registry_with_aging: FAILED **");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/srvreg_pkg.sv
hw/rtl/srvreg_ctrl.sv
hw/rtl/srvreg_dp.sv
hw/rtl/server_registry_with_aging.sv
bench/server_registry_with_aging_test.sv
